[rtl/mfmd_pkg.sv]
// ----------------------------------------------------------------------------
// mfmd_pkg
// Types, constants and register codes shared by the motor feedback decoder.
// ----------------------------------------------------------------------------
package mfmd_pkg;

	localparam int ID_W         = 11;
	localparam int BYTE_W       = 8;
	localparam int ANGLE_W      = 16;
	localparam int WORD_W       = 16;
	localparam int GC_W         = 14;
	localparam int ROUNDS_W     = 18;
	localparam int TOTAL_W      = 32;
	localparam int SLOT_W       = 3;
	localparam int CFG_IDX_W    = 3;
	localparam int CFG_DATA_W   = 16;
	localparam int ID_SLOTS     = 7;
	localparam int CHASSIS_SLOTS = 4;
	localparam int DEF_MOTOR_SLOTS = 7;
	localparam int TURN_SHIFT   = 13;
	localparam int RECIP_SHIFT  = 18;
	localparam int STATE_W      = ANGLE_W + ROUNDS_W;

	localparam logic signed [ANGLE_W:0] HALF_TURN     = 17'sd4096;
	localparam logic signed [ANGLE_W:0] NEG_HALF_TURN = -17'sd4096;
	localparam logic signed [ROUNDS_W-1:0] ROUND_MAX  = 18'sd131071;
	localparam logic signed [ROUNDS_W-1:0] ROUND_MIN  = -18'sd131072;
	localparam logic [WORD_W:0] DIV5_RECIP            = 17'd52429;

	localparam logic [CFG_IDX_W-1:0] REG_ANGLE_OFFSET = 3'd7;

	typedef logic [ID_W-1:0] id_arr_t [ID_SLOTS];

	localparam id_arr_t ID_RESET = '{11'd513, 11'd514, 11'd515, 11'd516,
		11'd517, 11'd518, 11'd519};

	typedef struct packed {
		logic [ID_SLOTS-1:0][ID_W-1:0] ids;
		logic [ANGLE_W-1:0]            offset;
	} cfg_t;

	typedef struct packed {
		logic              hit;
		logic [SLOT_W-1:0] slot;
	} match_t;

	typedef struct packed {
		logic [ANGLE_W-1:0]         prev_angle;
		logic signed [ROUNDS_W-1:0] rounds;
	} slot_state_t;

endpackage

[rtl/mfmd_if.sv]
// ----------------------------------------------------------------------------
// mfmd interfaces
// Frame input channel, result output channel and register write channel.
// ----------------------------------------------------------------------------
interface mfmd_in_if;
	logic                            valid;
	logic                            ready;
	logic                            bus;
	logic [mfmd_pkg::ID_W-1:0]       std_id;
	logic [mfmd_pkg::BYTE_W-1:0]     byte0;
	logic [mfmd_pkg::BYTE_W-1:0]     byte1;
	logic [mfmd_pkg::BYTE_W-1:0]     byte2;
	logic [mfmd_pkg::BYTE_W-1:0]     byte3;
	logic [mfmd_pkg::BYTE_W-1:0]     byte4;
	logic [mfmd_pkg::BYTE_W-1:0]     byte5;
	logic [mfmd_pkg::BYTE_W-1:0]     byte6;
	modport source (output valid, bus, std_id, byte0, byte1, byte2, byte3, byte4,
		byte5, byte6, input ready);
	modport sink (input valid, bus, std_id, byte0, byte1, byte2, byte3, byte4,
		byte5, byte6, output ready);
endinterface

interface mfmd_out_if;
	logic                                  valid;
	logic                                  ready;
	logic                                  matched;
	logic [mfmd_pkg::SLOT_W-1:0]           slot;
	logic [mfmd_pkg::ANGLE_W-1:0]          angle;
	logic signed [mfmd_pkg::WORD_W-1:0]    current_or_speed;
	logic signed [mfmd_pkg::GC_W-1:0]      set_current;
	logic [mfmd_pkg::BYTE_W-1:0]           hall;
	logic signed [mfmd_pkg::ROUNDS_W-1:0]  rounds;
	logic signed [mfmd_pkg::TOTAL_W-1:0]   multiturn_angle;
	modport source (output valid, matched, slot, angle, current_or_speed,
		set_current, hall, rounds, multiturn_angle, input ready);
	modport sink (input valid, matched, slot, angle, current_or_speed,
		set_current, hall, rounds, multiturn_angle, output ready);
endinterface

interface mfmd_cfg_if;
	logic                              valid;
	logic                              ready;
	logic [mfmd_pkg::CFG_IDX_W-1:0]    index;
	logic [mfmd_pkg::CFG_DATA_W-1:0]   data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

[rtl/mfmd_ram.sv]
// ----------------------------------------------------------------------------
// mfmd_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module mfmd_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 8,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

[rtl/mfmd_cfg.sv]
// ----------------------------------------------------------------------------
// mfmd_cfg
// Register file for motor IDs and angle offset, and slot lookup of a frame.
// ----------------------------------------------------------------------------
module mfmd_cfg #(
	parameter int MOTOR_SLOTS = mfmd_pkg::DEF_MOTOR_SLOTS
) (
	input  logic                      clk,
	input  logic                      arst_n,
	mfmd_cfg_if.sink                  cfg,
	input  logic                      bus,
	input  logic [mfmd_pkg::ID_W-1:0] std_id,
	output mfmd_pkg::match_t          match,
	output logic [mfmd_pkg::ANGLE_W-1:0] offset
);

	mfmd_pkg::cfg_t regs_q;

	assign cfg.ready = 1'b1;
	assign offset    = regs_q.offset;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < mfmd_pkg::ID_SLOTS; i++) begin
				regs_q.ids[i] <= mfmd_pkg::ID_RESET[i];
			end
			regs_q.offset <= '0;
		end else if (cfg.valid && cfg.ready) begin
			unique case (cfg.index)
				mfmd_pkg::REG_ANGLE_OFFSET: regs_q.offset <= cfg.data;
				default: regs_q.ids[cfg.index] <= cfg.data[mfmd_pkg::ID_W-1:0];
			endcase
		end
	end

	// lowest slot of the bus wins
	always_comb begin
		match = '0;
		for (int s = mfmd_pkg::ID_SLOTS - 1; s >= 0; s--) begin
			if (((s >= mfmd_pkg::CHASSIS_SLOTS) == bus) && (regs_q.ids[s] == std_id)
					&& (s < MOTOR_SLOTS)) begin
				match.hit  = 1'b1;
				match.slot = mfmd_pkg::SLOT_W'(s);
			end
		end
	end

endmodule

[rtl/mfmd_calc.sv]
// ----------------------------------------------------------------------------
// mfmd_calc
// Angle unwrap, round saturation, total angle and given current scaling.
// ----------------------------------------------------------------------------
module mfmd_calc (
	input  logic [mfmd_pkg::ANGLE_W-1:0]          angle,
	input  mfmd_pkg::slot_state_t                 old_state,
	input  logic [mfmd_pkg::ANGLE_W-1:0]          offset,
	input  logic signed [mfmd_pkg::WORD_W-1:0]    gc_word,
	output logic signed [mfmd_pkg::ROUNDS_W-1:0]  rounds,
	output logic signed [mfmd_pkg::TOTAL_W-1:0]   multiturn_angle,
	output logic signed [mfmd_pkg::GC_W-1:0]      set_current
);

	logic signed [mfmd_pkg::ANGLE_W:0]   diff;
	logic signed [mfmd_pkg::ROUNDS_W-1:0] r_old;
	logic [mfmd_pkg::WORD_W:0]           mag;
	logic [2*mfmd_pkg::WORD_W+1:0]       prod;
	logic [mfmd_pkg::GC_W-1:0]           quo;

	assign r_old = old_state.rounds;
	assign diff  = $signed({1'b0, angle}) - $signed({1'b0, old_state.prev_angle});

	always_comb begin
		rounds = r_old;
		if (diff > mfmd_pkg::HALF_TURN) begin
			if (r_old != mfmd_pkg::ROUND_MIN) begin
				rounds = r_old - 18'sd1;
			end
		end else if (diff < mfmd_pkg::NEG_HALF_TURN) begin
			if (r_old != mfmd_pkg::ROUND_MAX) begin
				rounds = r_old + 18'sd1;
			end
		end
	end

	assign multiturn_angle = $signed({rounds[mfmd_pkg::ROUNDS_W-1], rounds,
		{mfmd_pkg::TURN_SHIFT{1'b0}}})
		+ $signed({16'b0, angle}) - $signed({16'b0, offset});

	// magnitude over five by reciprocal, sign flipped for the negative divisor
	assign mag  = gc_word[mfmd_pkg::WORD_W-1]
		? (17'd0 - {gc_word[mfmd_pkg::WORD_W-1], gc_word})
		: {1'b0, gc_word};
	assign prod = mag * mfmd_pkg::DIV5_RECIP;
	assign quo  = prod[mfmd_pkg::RECIP_SHIFT +: mfmd_pkg::GC_W];
	assign set_current = gc_word[mfmd_pkg::WORD_W-1] ? $signed(quo)
		: $signed(14'd0 - quo);

endmodule

[rtl/motor_feedback_multiturn_decoder.sv]
// ----------------------------------------------------------------------------
// motor_feedback_multiturn_decoder
// Pipeline: a frame beat is registered into stage one at accept, then into
// stage two as it advances; its result beat is driven from stage two.
// Throughput: one frame per cycle; the per-slot state RAM is read at accept
// and written when the frame leaves stage one, with a forwarding register on
// the same slot. Input stalls only while a result beat is not taken.
// Reset: registers return to their default IDs and zero offset; valid flags
// per slot clear so every slot reads as zero angle and zero rounds.
// ----------------------------------------------------------------------------
module motor_feedback_multiturn_decoder #(
	parameter int MOTOR_SLOTS = mfmd_pkg::DEF_MOTOR_SLOTS
) (
	input  logic        clk,
	input  logic        arst_n,
	mfmd_cfg_if.sink    cfg,
	mfmd_in_if.sink     src,
	mfmd_out_if.source  dst
);

	localparam int AW = (MOTOR_SLOTS > 1) ? $clog2(MOTOR_SLOTS) : 1;

	mfmd_pkg::match_t               match;
	logic [mfmd_pkg::ANGLE_W-1:0]   offset;
	logic                           accept;
	logic                           adv_s1;
	logic                           wr_en;
	logic [AW-1:0]                  rd_addr;
	mfmd_pkg::slot_state_t          rd_data;
	mfmd_pkg::slot_state_t          old_state;
	mfmd_pkg::slot_state_t          new_state;

	logic                           valid_s1;
	logic                           hit_s1;
	logic [mfmd_pkg::SLOT_W-1:0]    slot_s1;
	logic                           fwd_s1;
	logic                           vld_s1;
	logic [mfmd_pkg::ANGLE_W-1:0]   angle_s1;
	logic [mfmd_pkg::WORD_W-1:0]    cur_s1;
	logic [mfmd_pkg::WORD_W-1:0]    gcw_s1;
	logic [mfmd_pkg::BYTE_W-1:0]    hall_s1;

	mfmd_pkg::slot_state_t          last_q;
	logic [MOTOR_SLOTS-1:0]         written_q;

	logic signed [mfmd_pkg::ROUNDS_W-1:0] rounds_c;
	logic signed [mfmd_pkg::TOTAL_W-1:0]  total_c;
	logic signed [mfmd_pkg::GC_W-1:0]     gc_c;

	logic                                 valid_s2;
	logic                                 hit_s2;
	logic [mfmd_pkg::SLOT_W-1:0]          slot_s2;
	logic [mfmd_pkg::ANGLE_W-1:0]         angle_s2;
	logic [mfmd_pkg::WORD_W-1:0]          cur_s2;
	logic signed [mfmd_pkg::GC_W-1:0]     gc_s2;
	logic [mfmd_pkg::BYTE_W-1:0]          hall_s2;
	logic signed [mfmd_pkg::ROUNDS_W-1:0] rounds_s2;
	logic signed [mfmd_pkg::TOTAL_W-1:0]  total_s2;

	mfmd_cfg #(.MOTOR_SLOTS(MOTOR_SLOTS)) u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.bus    (src.bus),
		.std_id (src.std_id),
		.match  (match),
		.offset (offset)
	);

	assign adv_s1    = valid_s1 && (!valid_s2 || dst.ready);
	assign src.ready = !valid_s1 || adv_s1;
	assign accept    = src.valid && src.ready;
	assign wr_en     = adv_s1 && hit_s1;
	assign rd_addr   = match.slot[AW-1:0];

	mfmd_ram #(.WIDTH(mfmd_pkg::STATE_W), .DEPTH(MOTOR_SLOTS)) u_ram (
		.clk   (clk),
		.we    (wr_en),
		.waddr (slot_s1[AW-1:0]),
		.wdata (new_state),
		.re    (accept && match.hit),
		.raddr (rd_addr),
		.rdata (rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1  <= 1'b0;
			valid_s2  <= 1'b0;
			written_q <= '0;
		end else begin
			if (accept) begin
				valid_s1 <= 1'b1;
			end else if (adv_s1) begin
				valid_s1 <= 1'b0;
			end
			if (adv_s1) begin
				valid_s2 <= 1'b1;
			end else if (dst.ready) begin
				valid_s2 <= 1'b0;
			end
			if (wr_en) begin
				written_q[slot_s1[AW-1:0]] <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			hit_s1   <= match.hit;
			slot_s1  <= match.slot;
			fwd_s1   <= wr_en && (slot_s1[AW-1:0] == rd_addr);
			vld_s1   <= written_q[rd_addr];
			angle_s1 <= {src.byte0, src.byte1};
			cur_s1   <= {src.byte2, src.byte3};
			gcw_s1   <= {src.byte4, src.byte5};
			hall_s1  <= src.byte6;
		end
		if (wr_en) begin
			last_q <= new_state;
		end
		if (adv_s1) begin
			hit_s2    <= hit_s1;
			slot_s2   <= slot_s1;
			angle_s2  <= angle_s1;
			cur_s2    <= cur_s1;
			gc_s2     <= gc_c;
			hall_s2   <= hall_s1;
			rounds_s2 <= rounds_c;
			total_s2  <= total_c;
		end
	end

	always_comb begin
		if (fwd_s1) begin
			old_state = last_q;
		end else if (vld_s1) begin
			old_state = rd_data;
		end else begin
			old_state = '0;
		end
	end

	mfmd_calc u_calc (
		.angle           (angle_s1),
		.old_state       (old_state),
		.offset          (offset),
		.gc_word         ($signed(gcw_s1)),
		.rounds          (rounds_c),
		.multiturn_angle (total_c),
		.set_current     (gc_c)
	);

	assign new_state.prev_angle = angle_s1;
	assign new_state.rounds     = rounds_c;

	assign dst.valid            = valid_s2;
	assign dst.matched          = hit_s2;
	assign dst.slot             = hit_s2 ? slot_s2 : '0;
	assign dst.angle            = hit_s2 ? angle_s2 : '0;
	assign dst.current_or_speed = hit_s2 ? $signed(cur_s2) : '0;
	assign dst.set_current      = hit_s2 ? gc_s2 : '0;
	assign dst.hall             = hit_s2 ? hall_s2 : '0;
	assign dst.rounds           = hit_s2 ? rounds_s2 : '0;
	assign dst.multiturn_angle  = hit_s2 ? total_s2 : '0;

endmodule

[tb/motor_feedback_multiturn_decoder_tb.sv]
// ----------------------------------------------------------------------------
// motor_feedback_multiturn_decoder_tb
// Self-checking bench for the motor feedback decoder. Frames are queued by a
// sequencer, driven by a clocked driver and decoded by a local predictor at
// each accepted beat. A clocked monitor compares every result beat with the
// oldest prediction. Phases cover reset IDs, duplicate and extreme IDs, random
// IDs and offsets, a long output stall, and multi-turn laps both ways.
// ----------------------------------------------------------------------------
module motor_feedback_multiturn_decoder_tb;

	localparam int MOTOR_SLOTS = mfmd_pkg::DEF_MOTOR_SLOTS;
	localparam int TURN_HALF = 4096;
	localparam int TURN_FULL = 8192;
	localparam int GC_DIVISOR = -5;
	localparam int LATENCY_PAD = 6;
	localparam int STALL_CYCLES = 300;
	localparam int SPIN_LAPS = 4;
	localparam int RANDOM_FRAMES = 130;
	localparam int QUEUE_DEPTH = 64;
	localparam int MAX_REPORTS = 10;
	localparam longint CYCLE_LIMIT = 100000;

	localparam logic [mfmd_pkg::CFG_IDX_W-1:0] REG_ID_FL     = 3'd0;
	localparam logic [mfmd_pkg::CFG_IDX_W-1:0] REG_ID_FR     = 3'd1;
	localparam logic [mfmd_pkg::CFG_IDX_W-1:0] REG_ID_RL     = 3'd2;
	localparam logic [mfmd_pkg::CFG_IDX_W-1:0] REG_ID_RR     = 3'd3;
	localparam logic [mfmd_pkg::CFG_IDX_W-1:0] REG_ID_YAW    = 3'd4;
	localparam logic [mfmd_pkg::CFG_IDX_W-1:0] REG_ID_PITCH  = 3'd5;
	localparam logic [mfmd_pkg::CFG_IDX_W-1:0] REG_ID_FEEDER = 3'd6;

	typedef struct packed {
		logic                                bus;
		logic [mfmd_pkg::ID_W-1:0]           std_id;
		logic [6:0][mfmd_pkg::BYTE_W-1:0]    data;
	} frame_t;

	typedef struct packed {
		logic                                  matched;
		logic [mfmd_pkg::SLOT_W-1:0]           slot;
		logic [mfmd_pkg::ANGLE_W-1:0]          angle;
		logic signed [mfmd_pkg::WORD_W-1:0]    cur;
		logic signed [mfmd_pkg::GC_W-1:0]      gc;
		logic [mfmd_pkg::BYTE_W-1:0]           hall;
		logic signed [mfmd_pkg::ROUNDS_W-1:0]  rounds;
		logic signed [mfmd_pkg::TOTAL_W-1:0]   total;
	} feedback_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	mfmd_in_if  src_if ();
	mfmd_out_if dst_if ();
	mfmd_cfg_if cfg_if ();

	logic                            in_valid = 1'b0;
	frame_t                          in_frame = '0;
	logic                            out_ready = 1'b0;
	logic                            cfg_valid = 1'b0;
	logic [mfmd_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
	logic [mfmd_pkg::CFG_DATA_W-1:0] cfg_data = '0;

	assign src_if.valid  = in_valid;
	assign src_if.bus    = in_frame.bus;
	assign src_if.std_id = in_frame.std_id;
	assign src_if.byte0  = in_frame.data[0];
	assign src_if.byte1  = in_frame.data[1];
	assign src_if.byte2  = in_frame.data[2];
	assign src_if.byte3  = in_frame.data[3];
	assign src_if.byte4  = in_frame.data[4];
	assign src_if.byte5  = in_frame.data[5];
	assign src_if.byte6  = in_frame.data[6];
	assign dst_if.ready  = out_ready;
	assign cfg_if.valid  = cfg_valid;
	assign cfg_if.index  = cfg_index;
	assign cfg_if.data   = cfg_data;

	motor_feedback_multiturn_decoder #(
		.MOTOR_SLOTS(MOTOR_SLOTS)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg_if),
		.src(src_if),
		.dst(dst_if)
	);

	logic [mfmd_pkg::ID_W-1:0]            id_cfg [mfmd_pkg::ID_SLOTS];
	logic [mfmd_pkg::ANGLE_W-1:0]         offset_cfg;
	logic [mfmd_pkg::ANGLE_W-1:0]         prev_ang [MOTOR_SLOTS];
	logic signed [mfmd_pkg::ROUNDS_W-1:0] turn_count [MOTOR_SLOTS];
	logic [mfmd_pkg::ANGLE_W-1:0]         gen_angle [MOTOR_SLOTS];

	frame_t    pending [$];
	feedback_t feedback_q [$];
	feedback_t seen;
	feedback_t want;

	int     src_idle_pct = 0;
	int     dst_idle_pct = 0;
	int     frames_queued = 0;
	int     frames_accepted = 0;
	int     results_seen = 0;
	int     hits = 0;
	int     limit_hits = 0;
	int     errors = 0;
	longint cycles = 0;
	bit     stall_req = 1'b0;
	bit     stall_ack = 1'b0;
	int     stall_left = 0;

	function automatic feedback_t decode_frame(frame_t f);
		feedback_t r;
		int s;
		int lo;
		int hi;
		int d;
		int gcq;
		logic [mfmd_pkg::ANGLE_W-1:0] ang;
		logic signed [mfmd_pkg::WORD_W-1:0] gw;
		logic signed [mfmd_pkg::ROUNDS_W-1:0] rc;
		longint tot;
		r = '0;
		s = -1;
		lo = f.bus ? mfmd_pkg::CHASSIS_SLOTS : 0;
		hi = f.bus ? mfmd_pkg::ID_SLOTS - 1 : mfmd_pkg::CHASSIS_SLOTS - 1;
		for (int i = hi; i >= lo; i--)
			if (id_cfg[i] == f.std_id)
				s = i;
		if (s < 0 || s >= MOTOR_SLOTS)
			return r;
		ang = {f.data[0], f.data[1]};
		d = int'(ang) - int'(prev_ang[s]);
		rc = turn_count[s];
		if (d > TURN_HALF) begin
			if (rc != mfmd_pkg::ROUND_MIN)
				rc = rc - 1;
		end else if (d < -TURN_HALF) begin
			if (rc != mfmd_pkg::ROUND_MAX)
				rc = rc + 1;
		end
		turn_count[s] = rc;
		prev_ang[s] = ang;
		gw = {f.data[4], f.data[5]};
		gcq = int'(gw) / GC_DIVISOR;
		tot = longint'(rc) * TURN_FULL + longint'(ang) - longint'(offset_cfg);
		r.matched = 1'b1;
		r.slot = mfmd_pkg::SLOT_W'(s);
		r.angle = ang;
		r.cur = {f.data[2], f.data[3]};
		r.gc = gcq[mfmd_pkg::GC_W-1:0];
		r.hall = f.data[6];
		r.rounds = rc;
		r.total = tot[mfmd_pkg::TOTAL_W-1:0];
		hits++;
		if (rc == mfmd_pkg::ROUND_MAX || rc == mfmd_pkg::ROUND_MIN)
			limit_hits++;
		return r;
	endfunction

	function automatic frame_t make_frame(logic bus, logic [mfmd_pkg::ID_W-1:0] id,
		logic [15:0] ang, logic [15:0] cur, logic [15:0] gc, logic [7:0] hall);
		frame_t f;
		f.bus = bus;
		f.std_id = id;
		f.data[0] = ang[15:8];
		f.data[1] = ang[7:0];
		f.data[2] = cur[15:8];
		f.data[3] = cur[7:0];
		f.data[4] = gc[15:8];
		f.data[5] = gc[7:0];
		f.data[6] = hall;
		return f;
	endfunction

	function automatic frame_t random_frame();
		int s;
		int dl;
		logic [mfmd_pkg::ANGLE_W-1:0] ang;
		frame_t f;
		s = $urandom_range(MOTOR_SLOTS - 1);
		ang = mfmd_pkg::ANGLE_W'($urandom);
		if ($urandom_range(99) < 80) begin
			if ($urandom_range(1) == 0) begin
				case ($urandom_range(3))
					0: dl = TURN_HALF;
					1: dl = -TURN_HALF;
					2: dl = ($urandom_range(1) == 0) ? TURN_HALF + 1 : -TURN_HALF - 1;
					default: dl = int'($urandom_range(2 * TURN_HALF + 200)) - TURN_HALF - 100;
				endcase
				ang = gen_angle[s] + mfmd_pkg::ANGLE_W'(dl);
			end
			gen_angle[s] = ang;
			f = make_frame(s >= mfmd_pkg::CHASSIS_SLOTS, id_cfg[s], ang, 16'($urandom),
				16'($urandom), 8'($urandom));
		end else begin
			f = make_frame(1'($urandom), mfmd_pkg::ID_W'($urandom), ang, 16'($urandom),
				16'($urandom), 8'($urandom));
		end
		return f;
	endfunction

	function automatic string show(feedback_t v);
		return $sformatf("m=%0b slot=%0d ang=%0d cur=%0d gc=%0d hall=%0d rnd=%0d tot=%0d",
			v.matched, v.slot, v.angle, $signed(v.cur), $signed(v.gc), v.hall,
			$signed(v.rounds), $signed(v.total));
	endfunction

	task automatic write_reg(logic [mfmd_pkg::CFG_IDX_W-1:0] idx,
		logic [mfmd_pkg::CFG_DATA_W-1:0] val);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_if.ready);
		cfg_valid <= 1'b0;
		if (idx == mfmd_pkg::REG_ANGLE_OFFSET)
			offset_cfg = val;
		else
			id_cfg[idx] = val[mfmd_pkg::ID_W-1:0];
	endtask

	task automatic push_frame(frame_t f);
		while (pending.size() >= QUEUE_DEPTH)
			@(posedge clk);
		pending.push_back(f);
		frames_queued++;
	endtask

	task automatic wait_drained();
		do @(posedge clk); while (results_seen < frames_queued);
		repeat (LATENCY_PAD) @(posedge clk);
	endtask

	task automatic set_idle(int s, int d);
		src_idle_pct = s;
		dst_idle_pct = d;
	endtask

	task automatic run_random(int n);
		repeat (n) push_frame(random_frame());
		wait_drained();
	endtask

	// drive laps of 0 -> a1 -> a2 -> 0; one full-turn jump per lap
	task automatic spin_laps(logic bus, logic [mfmd_pkg::ID_W-1:0] id, logic [15:0] a1,
		logic [15:0] a2);
		push_frame(make_frame(bus, id, 16'd0, 16'($urandom), 16'($urandom), 8'($urandom)));
		repeat (SPIN_LAPS) begin
			push_frame(make_frame(bus, id, a1, 16'($urandom), 16'($urandom), 8'($urandom)));
			push_frame(make_frame(bus, id, a2, 16'($urandom), 16'($urandom), 8'($urandom)));
			push_frame(make_frame(bus, id, 16'd0, 16'($urandom), 16'($urandom),
				8'($urandom)));
		end
	endtask

	initial begin
		forever #10 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("motor_feedback_multiturn_decoder_tb: errors");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (stall_req != stall_ack) begin
			stall_left <= STALL_CYCLES;
			stall_ack <= stall_req;
		end else if (stall_left != 0) begin
			stall_left <= stall_left - 1;
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && src_if.ready) begin
				feedback_q.push_back(decode_frame(in_frame));
				frames_accepted++;
			end
			if (!in_valid || src_if.ready) begin
				if (pending.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
					in_frame <= pending.pop_front();
					in_valid <= 1'b1;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (dst_if.valid && out_ready) begin
				seen.matched = dst_if.matched;
				seen.slot = dst_if.slot;
				seen.angle = dst_if.angle;
				seen.cur = dst_if.current_or_speed;
				seen.gc = dst_if.set_current;
				seen.hall = dst_if.hall;
				seen.rounds = dst_if.rounds;
				seen.total = dst_if.multiturn_angle;
				results_seen++;
				if (feedback_q.size() == 0) begin
					errors++;
					if (errors <= MAX_REPORTS)
						$display("unexpected result beat: %s", show(seen));
				end else begin
					want = feedback_q.pop_front();
					if (seen !== want) begin
						errors++;
						if (errors <= MAX_REPORTS) begin
							$display("mismatch expected: %s", show(want));
							$display("         actual:   %s", show(seen));
						end
					end
				end
			end
			out_ready <= (stall_left == 0) && ($urandom_range(99) >= dst_idle_pct);
		end
	end

	initial begin
		for (int s = 0; s < mfmd_pkg::ID_SLOTS; s++)
			id_cfg[s] = mfmd_pkg::ID_RESET[s];
		offset_cfg = '0;
		for (int s = 0; s < MOTOR_SLOTS; s++) begin
			prev_ang[s] = '0;
			turn_count[s] = '0;
			gen_angle[s] = '0;
		end
		set_idle(19, 82);
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		// reset IDs: field extremes, jumps on both sides of a half turn, misses
		push_frame(make_frame(1'b0, 11'd513, 16'h0000, 16'h7FFF, 16'h8000, 8'h00));
		push_frame(make_frame(1'b0, 11'd513, 16'hFFFF, 16'h8000, 16'h7FFF, 8'hFF));
		push_frame(make_frame(1'b0, 11'd513, 16'h0000, 16'h0000, 16'hFFFB, 8'h5A));
		push_frame(make_frame(1'b0, 11'd514, 16'd4096, 16'hFFFF, 16'h0005, 8'hA5));
		push_frame(make_frame(1'b0, 11'd514, 16'd8193, 16'h0001, 16'hFFFF, 8'h01));
		push_frame(make_frame(1'b0, 11'd514, 16'd4096, 16'h1234, 16'h0004, 8'h80));
		push_frame(make_frame(1'b0, 11'd514, 16'd0, 16'hFEDC, 16'hFFFC, 8'h7F));
		push_frame(make_frame(1'b0, 11'd515, 16'd4097, 16'h5555, 16'h8001, 8'h33));
		push_frame(make_frame(1'b0, 11'd516, 16'd4096, 16'hAAAA, 16'h7FFA, 8'hCC));
		push_frame(make_frame(1'b1, 11'd517, 16'hC000, 16'h0F0F, 16'hFFFA, 8'h0F));
		push_frame(make_frame(1'b1, 11'd518, 16'h0FFF, 16'hF0F0, 16'h0006, 8'hF0));
		push_frame(make_frame(1'b1, 11'd519, 16'h8000, 16'h00FF, 16'h0001, 8'h55));
		push_frame(make_frame(1'b1, 11'd513, 16'h1111, 16'h2222, 16'h3333, 8'h44));
		push_frame(make_frame(1'b0, 11'd517, 16'h9999, 16'h8888, 16'h7777, 8'h66));
		push_frame(make_frame(1'b0, 11'd0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 8'hFF));
		push_frame(make_frame(1'b1, 11'd2047, 16'hFFFF, 16'hFFFF, 16'hFFFF, 8'hFF));
		push_frame(make_frame(1'b1, 11'd517, 16'h4000, 16'h0000, 16'h0000, 8'h00));
		push_frame(make_frame(1'b1, 11'd519, 16'h0000, 16'h8000, 16'h8000, 8'hAA));
		wait_drained();

		// duplicate and extreme IDs, full offset; upper data bits on some IDs
		write_reg(REG_ID_FL, 16'h0000);
		write_reg(REG_ID_FR, 16'h0000);
		write_reg(REG_ID_RL, 16'h07FF);
		write_reg(REG_ID_RR, 16'hFFFF);
		write_reg(REG_ID_YAW, 16'hF800);
		write_reg(REG_ID_PITCH, 16'h07FF);
		write_reg(REG_ID_FEEDER, 16'h07FF);
		write_reg(mfmd_pkg::REG_ANGLE_OFFSET, 16'hFFFF);
		push_frame(make_frame(1'b0, 11'd0, 16'h2000, 16'h0102, 16'h0304, 8'h05));
		push_frame(make_frame(1'b0, 11'd2047, 16'hF000, 16'h0607, 16'h0809, 8'h0A));
		push_frame(make_frame(1'b1, 11'd0, 16'h0000, 16'h0B0C, 16'h0D0E, 8'h0F));
		push_frame(make_frame(1'b1, 11'd2047, 16'hFFFF, 16'h1011, 16'h1213, 8'h14));
		run_random(RANDOM_FRAMES);

		set_idle(82, 19);
		for (int s = 0; s < mfmd_pkg::ID_SLOTS; s++)
			write_reg(mfmd_pkg::CFG_IDX_W'(s), 16'($urandom));
		write_reg(mfmd_pkg::REG_ANGLE_OFFSET, 16'($urandom));
		run_random(RANDOM_FRAMES);

		set_idle(0, 0);
		for (int s = 0; s < mfmd_pkg::ID_SLOTS; s++)
			write_reg(mfmd_pkg::CFG_IDX_W'(s), 16'($urandom_range(2047)));
		write_reg(mfmd_pkg::REG_ANGLE_OFFSET, 16'h0000);
		stall_req = ~stall_req;
		run_random(RANDOM_FRAMES);

		// step rounds upward by laps, then climb to the top angle with zero offset
		for (int s = 0; s < mfmd_pkg::ID_SLOTS; s++)
			write_reg(mfmd_pkg::CFG_IDX_W'(s),
				mfmd_pkg::CFG_DATA_W'(mfmd_pkg::ID_RESET[s]));
		spin_laps(1'b1, mfmd_pkg::ID_RESET[REG_ID_YAW], 16'd4096, 16'd8192);
		for (int a = TURN_HALF; a < 65536; a += TURN_HALF)
			push_frame(make_frame(1'b1, mfmd_pkg::ID_RESET[REG_ID_YAW], 16'(a),
				16'($urandom), 16'($urandom), 8'($urandom)));
		push_frame(make_frame(1'b1, mfmd_pkg::ID_RESET[REG_ID_YAW], 16'hFFFF,
			16'($urandom), 16'($urandom), 8'($urandom)));
		wait_drained();

		// step rounds downward under full offset, ending on angle zero
		write_reg(mfmd_pkg::REG_ANGLE_OFFSET, 16'hFFFF);
		spin_laps(1'b0, mfmd_pkg::ID_RESET[REG_ID_FL], 16'd8192, 16'd4096);
		wait_drained();

		if (feedback_q.size() != 0) begin
			errors++;
			$display("%0d predicted results never arrived", feedback_q.size());
		end
		$display("run covered %0d frames, %0d hit a slot, %0d at a round-count limit",
			frames_accepted, hits, limit_hits);
		$display("configs: reset IDs, duplicate/extreme IDs, random IDs and offsets, %0d errors",
			errors);
		if (errors == 0)
			$display("motor_feedback_multiturn_decoder_tb: clean");
		else
			$display("motor_feedback_multiturn_decoder_tb: errors");
		$finish;
	end

endmodule
